// File: rtl/xbtd_pkg.sv
// ---------------------------------------------------------------------------
// xbtd_pkg - shared types and constants for the x86 branch target decoder
// Window geometry, header length, opcode bytes and the request bundle that
// travels from the filter stage to the output drain.
// ---------------------------------------------------------------------------
package xbtd_pkg;

  // Payload positions are grouped into blocks of this size (power of two)
  localparam int unsigned BLOCK_SIZE = 65536;
  localparam int unsigned BLOCK_BITS = $clog2(BLOCK_SIZE);

  localparam int unsigned WIN_LEN  = 6;
  localparam int unsigned IDX_W    = $clog2(WIN_LEN);
  localparam int unsigned HDR_LEN  = 4;
  localparam int unsigned FILL_LEN = WIN_LEN - 1;
  localparam int unsigned CNT_W    = 3;

  // Branch opcodes and markers
  localparam logic [7:0] OP_CALL     = 8'hE8;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [3:0] OP_JCC_HI   = 4'h8;
  localparam logic [7:0] TAIL_ZERO   = 8'h00;
  localparam logic [7:0] TAIL_ONES   = 8'hFF;
  localparam logic [7:0] XOR_KEY     = 8'd176;

  // Rewrite arithmetic works on the low 25 bits (24 bits plus sign)
  localparam int unsigned ADDR_W = 25;

  typedef logic [WIN_LEN-1:0][7:0] window_t;

  // Output bundle: window snapshot drained from start_idx down
  typedef struct packed {
    logic             load;
    window_t          bytes;
    logic [IDX_W-1:0] start_idx;
    logic             to_zero;
    logic             ends;
  } bundle_t;

endpackage

// File: rtl/xbtd_if.sv
// ---------------------------------------------------------------------------
// xbtd_if - valid/ready channels of the x86 branch target decoder
// Input channel carries stream bytes, output channel restored bytes.
// ---------------------------------------------------------------------------
interface xbtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xbtd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/xbtd_filter.sv
// ---------------------------------------------------------------------------
// xbtd_filter - input register, stream state and window rewrite
// Collects the header, shifts payload bytes into the six-byte window,
// restores branch targets and hands the resulting bytes to the drain.
// ---------------------------------------------------------------------------
module xbtd_filter (
  input  logic            clk,
  input  logic            rst_n,
  xbtd_in_if.sink         in_ch,
  input  logic            bundle_free,
  output xbtd_pkg::bundle_t bundle
);

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Stream state
  xbtd_pkg::window_t                win_r, win_nxt;
  logic [31:0]                      base_r, base_nxt;
  logic [31:0]                      pos_r, pos_nxt;
  logic [xbtd_pkg::CNT_W-1:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [xbtd_pkg::CNT_W-1:0]       fill_cnt_r, fill_cnt_nxt;

  logic                             in_hdr;
  logic                             go;
  xbtd_pkg::window_t                win_shift;
  xbtd_pkg::window_t                win_fix;
  logic                             head_ok, tail_ok, same_blk;
  logic [xbtd_pkg::ADDR_W-1:0]      raw_addr, rel_addr;
  logic [31:0]                      pos_inc;

  assign in_hdr = hdr_cnt_r < xbtd_pkg::CNT_W'(xbtd_pkg::HDR_LEN);
  // Header bytes never produce output, so they need no free drain
  assign go = in_valid_r && (in_hdr || bundle_free);
  // No request is taken while reset is held
  assign in_ch.ready = rst_n && (!in_valid_r || go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
      in_last_r <= in_ch.in_last;
    end
  end

  // Window with the new byte shifted in at index 0
  assign win_shift = {win_r[xbtd_pkg::WIN_LEN-2:0], in_byte_r};
  assign pos_inc   = pos_r + 32'd1;

  // Branch pattern test on the shifted window
  assign head_ok = (win_shift[4] == xbtd_pkg::OP_CALL) ||
                   (win_shift[4] == xbtd_pkg::OP_JMP) ||
                   (win_shift[5] == xbtd_pkg::OP_ESC &&
                    win_shift[4][7:4] == xbtd_pkg::OP_JCC_HI);
  assign tail_ok = (win_shift[0] == xbtd_pkg::TAIL_ZERO) ||
                   (win_shift[0] == xbtd_pkg::TAIL_ONES);
  // Newest sits at pos_r, oldest five earlier: same block unless we crossed
  assign same_blk = pos_r[xbtd_pkg::BLOCK_BITS-1:0] >=
                    xbtd_pkg::BLOCK_BITS'(xbtd_pkg::FILL_LEN);

  // Absolute to relative target, 25 bits are enough for the result
  assign raw_addr = {win_shift[0][0],
                     win_shift[3] ^ xbtd_pkg::XOR_KEY,
                     win_shift[2] ^ xbtd_pkg::XOR_KEY,
                     win_shift[1] ^ xbtd_pkg::XOR_KEY};
  assign rel_addr = raw_addr - pos_inc[xbtd_pkg::ADDR_W-1:0]
                    - base_r[xbtd_pkg::ADDR_W-1:0];

  always_comb begin
    win_fix = win_shift;
    if (head_ok && tail_ok && same_blk) begin
      win_fix[3] = rel_addr[7:0];
      win_fix[2] = rel_addr[15:8];
      win_fix[1] = rel_addr[23:16];
      win_fix[0] = {8{rel_addr[xbtd_pkg::ADDR_W-1]}};
    end
  end

  // Next state and output bundle
  always_comb begin
    win_nxt      = win_r;
    base_nxt     = base_r;
    pos_nxt      = pos_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    fill_cnt_nxt = fill_cnt_r;
    bundle       = '0;
    if (go) begin
      if (in_hdr) begin
        base_nxt    = {base_r[23:0], in_byte_r};
        hdr_cnt_nxt = hdr_cnt_r + 1'b1;
      end else if (fill_cnt_r < xbtd_pkg::CNT_W'(xbtd_pkg::FILL_LEN)) begin
        pos_nxt          = pos_inc;
        win_nxt          = win_shift;
        fill_cnt_nxt     = fill_cnt_r + 1'b1;
        // Short stream: flush what is held, oldest first
        bundle.load      = in_last_r;
        bundle.bytes     = win_shift;
        bundle.start_idx = xbtd_pkg::IDX_W'(fill_cnt_r);
        bundle.to_zero   = 1'b1;
        bundle.ends      = 1'b1;
      end else begin
        pos_nxt          = pos_inc;
        win_nxt          = win_fix;
        bundle.load      = 1'b1;
        bundle.bytes     = win_fix;
        bundle.start_idx = xbtd_pkg::IDX_W'(xbtd_pkg::WIN_LEN - 1);
        bundle.to_zero   = in_last_r;
        bundle.ends      = in_last_r;
      end
      // End of stream: back to the reset state
      if (in_last_r) begin
        base_nxt     = '0;
        pos_nxt      = '0;
        hdr_cnt_nxt  = '0;
        fill_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      pos_r      <= '0;
      hdr_cnt_r  <= '0;
      fill_cnt_r <= '0;
    end else begin
      base_r     <= base_nxt;
      pos_r      <= pos_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // Output only comes once the header is complete
  a_load_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    bundle.load |-> hdr_cnt_r == xbtd_pkg::CNT_W'(xbtd_pkg::HDR_LEN))
    else $error("output request before header complete");

  // Window filling only starts after the header
  a_fill_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r != '0 |-> hdr_cnt_r == xbtd_pkg::CNT_W'(xbtd_pkg::HDR_LEN))
    else $error("payload counted during header");

  // Last byte returns stream state to reset
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_last_r |=> hdr_cnt_r == '0 && fill_cnt_r == '0 && pos_r == '0)
    else $error("stream state not cleared after last byte");

endmodule

// File: rtl/xbtd_drain.sv
// ---------------------------------------------------------------------------
// xbtd_drain - output register for restored bytes
// Holds one window snapshot and sends its bytes one request per cycle
// while out_ch.ready is high, oldest first.
// ---------------------------------------------------------------------------
module xbtd_drain (
  input  logic              clk,
  input  logic              rst_n,
  input  xbtd_pkg::bundle_t bundle,
  output logic              bundle_free,
  xbtd_out_if.source        out_ch
);

  logic                       valid_r;
  logic [xbtd_pkg::IDX_W-1:0] idx_r;
  logic                       to_zero_r;
  logic                       ends_r;
  xbtd_pkg::window_t          bytes_r;
  logic                       at_stop;
  logic                       fire;

  assign at_stop     = !to_zero_r || idx_r == '0;
  assign fire        = valid_r && out_ch.ready;
  assign bundle_free = !valid_r || (fire && at_stop);

  assign out_ch.valid    = valid_r;
  assign out_ch.out_byte = bytes_r[idx_r];
  assign out_ch.out_last = ends_r && idx_r == '0;

  // Walk the snapshot down toward the newest byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (bundle.load) begin
      valid_r <= 1'b1;
    end else if (fire && at_stop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.load) begin
      bytes_r   <= bundle.bytes;
      idx_r     <= bundle.start_idx;
      to_zero_r <= bundle.to_zero;
      ends_r    <= bundle.ends;
    end else if (fire && !at_stop) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  // A new snapshot never overwrites bytes still waiting
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    bundle.load |-> bundle_free)
    else $error("drain overwritten while busy");

  // A single-byte request always sends the oldest window byte
  a_single_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !to_zero_r |-> idx_r == xbtd_pkg::IDX_W'(xbtd_pkg::WIN_LEN - 1))
    else $error("single-byte request not at oldest slot");

endmodule

// File: rtl/x86_branch_target_decode.sv
// ---------------------------------------------------------------------------
// x86_branch_target_decode - x86 call/jump target restore, decode side
// Top level: filter stage feeding the output drain.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  takes one stream byte per request, in_last on the final byte.
//          The first four bytes of a stream are a big-endian base address;
//          the rest is payload passed through a six-byte window.
//   out_ch gives restored payload bytes, out_last on the final one.
// Path: a byte that pushes a result out of the full window enters the input
//   register, then loads the output register, and out_ch takes it there.
//   Steady state: one byte per cycle while out_ch.ready is high.
// Stream end: the last byte flushes up to six bytes, one per cycle while
//   out_ch.ready is high, from the single output register. Meanwhile the
//   next stream's header bytes keep flowing, and its first payload byte
//   waits in the input register.
// Reset: rst_n low clears all stream state but the window and holds
//   in_ch.ready low; the next byte starts a header.
// Stall: when out_ch.ready is low the result holds in the output register,
//   the input register still takes one byte, then in_ch.ready drops.
//   Header bytes keep flowing since they produce no output.
// ---------------------------------------------------------------------------
module x86_branch_target_decode (
  input  logic        clk,
  input  logic        rst_n,
  xbtd_in_if.sink     in_ch,
  xbtd_out_if.source  out_ch
);

  xbtd_pkg::bundle_t bundle;
  logic              bundle_free;

  xbtd_filter u_filter (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .bundle_free (bundle_free),
    .bundle      (bundle)
  );

  xbtd_drain u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .bundle      (bundle),
    .bundle_free (bundle_free),
    .out_ch      (out_ch)
  );

endmodule
